// File: rtl/round_robin_task_scheduler_unit_defines.svh
// assertion macros for the round robin task scheduler checker
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, expects clk and rst_n in the using scope
`define RRTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, expects clk and rst_n in the using scope
`define RRTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rrts_pkg.sv
// shared types and constants of the round robin task scheduler
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  localparam int TC_W     = 5;
  localparam int IDX_W    = 4;
  localparam int ST_W     = 2;
  localparam int DLY_IN_W = 16;
  localparam int TASK_W   = 4;

  localparam logic [1:0] OP_DISPATCH = 2'd0;
  localparam logic [1:0] OP_YIELD    = 2'd1;
  localparam logic [1:0] OP_WRITE    = 2'd2;

  localparam logic [ST_W-1:0] TS_READY   = 2'd0;
  localparam logic [ST_W-1:0] TS_RUNNING = 2'd1;
  localparam logic [ST_W-1:0] TS_BLOCKED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_CD,
    S_CUR_RD,
    S_CUR_WB,
    S_SRCH,
    S_PICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic cap;
    logic wr_slot;
    logic cd;
    logic cur_rd;
    logic cur_wb;
    logic srch;
    logic pick;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_sched;
    logic cd_done;
    logic srch_hit;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/rrts_ifs.sv
// request, result and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface rrts_in_if;
  import rrts_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [IDX_W-1:0]    slot_index;
  logic [ST_W-1:0]     slot_state;
  logic [DLY_IN_W-1:0] slot_delay;
  modport source (output valid, opcode, slot_index, slot_state, slot_delay, input ready);
  modport sink   (input valid, opcode, slot_index, slot_state, slot_delay, output ready);
endinterface

interface rrts_out_if;
  import rrts_pkg::*;
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] next_task;
  logic              went_idle;
  modport source (output valid, next_task, went_idle, input ready);
  modport sink   (input valid, next_task, went_idle, output ready);
endinterface

interface rrts_cfg_if;
  import rrts_pkg::*;
  logic            valid;
  logic            ready;
  logic [TC_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/rrts_ctrl.sv
// scheduler sequencer: steps slot write, countdown, current update, search and result
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rrts_pkg::dp_sts_t sts,
  output rrts_pkg::dp_cmd_t cmd
);
  import rrts_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_sched ? S_CD : S_WRITE;
        end
      end
      S_WRITE:  state_nxt = S_DONE;
      S_CD: begin
        if (sts.cd_done) begin
          state_nxt = S_CUR_RD;
        end
      end
      S_CUR_RD: state_nxt = S_CUR_WB;
      S_CUR_WB: state_nxt = S_SRCH;
      S_SRCH: begin
        if (sts.srch_hit) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK:   state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.cap      = in_valid;
      end
      S_WRITE:  cmd.wr_slot = 1'b1;
      S_CD:     cmd.cd      = 1'b1;
      S_CUR_RD: cmd.cur_rd  = 1'b1;
      S_CUR_WB: cmd.cur_wb  = 1'b1;
      S_SRCH:   cmd.srch    = 1'b1;
      S_PICK:   cmd.pick    = 1'b1;
      S_DONE:   cmd.load    = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rrts_datapath.sv
// task state and delay memories, ring walk pointers and result register
`timescale 1ns / 1ps
`default_nettype none

module rrts_datapath #(
  parameter int MAX_TASKS  = 16,
  parameter int DELAY_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rrts_pkg::dp_cmd_t              cmd,
  output rrts_pkg::dp_sts_t              sts,
  input  logic [1:0]                     in_opcode,
  input  logic [rrts_pkg::IDX_W-1:0]     in_slot_index,
  input  logic [rrts_pkg::ST_W-1:0]      in_slot_state,
  input  logic [rrts_pkg::DLY_IN_W-1:0]  in_slot_delay,
  input  logic                           cfg_valid,
  input  logic [rrts_pkg::TC_W-1:0]      cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rrts_pkg::TASK_W-1:0]    out_next_task,
  output logic                           out_went_idle
);
  import rrts_pkg::*;

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  // memories
  logic [ST_W-1:0]       st_mem [MAX_TASKS];
  logic [DELAY_BITS-1:0] dl_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0]  st_vld_r;
  logic [MAX_TASKS-1:0]  dl_vld_r;
  logic [ST_W-1:0]       st_q_r;
  logic [DELAY_BITS-1:0] dl_q_r;
  logic                  st_qv_r;
  logic                  dl_qv_r;

  // control and payload registers
  logic [TC_W-1:0]     task_count_r;
  logic [AW-1:0]       cur_task_r;
  logic                out_valid_r;
  logic [1:0]          op_r;
  logic [IDX_W-1:0]    idx_r;
  logic [ST_W-1:0]     sst_r;
  logic [DLY_IN_W-1:0] sdel_r;
  logic [AW-1:0]       cur_r;
  logic [CW-1:0]       ra_r;
  logic [AW-1:0]       ea_r;
  logic                rv_r;
  logic [AW-1:0]       pick_r;
  logic [TASK_W-1:0]   next_task_r;
  logic                went_idle_r;

  logic [CW-1:0]       ring_n;
  logic [CW-1:0]       ra_inc;
  logic [CW-1:0]       ra_nxt;
  logic [CW-1:0]       cur_inc;
  logic [CW-1:0]       cur_nx;
  logic [AW-1:0]       cur_clamp;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                st_we;
  logic [AW-1:0]       st_wa;
  logic [ST_W-1:0]     st_wd;
  logic                dl_we;
  logic [AW-1:0]       dl_wa;
  logic [DELAY_BITS-1:0] dl_wd;
  logic [ST_W-1:0]     eff_st;
  logic [DELAY_BITS-1:0] eff_dl;
  logic [DELAY_BITS-1:0] dl_dec;
  logic                hit;
  logic                srch_hit;
  logic [AW-1:0]       srch_pick;
  logic [AW+IDX_W-1:0] idx_ext;
  logic                idx_ok;
  logic [AW+IDX_W-1:0] widx_ext;
  logic [DELAY_BITS+DLY_IN_W-1:0] sdel_ext;
  logic [AW+TASK_W-1:0] cur_wide;
  logic                op_sched;

  // ring size clamped into one to the storage depth
  always_comb begin
    if (task_count_r == '0) begin
      ring_n = CW'(1);
    end else if (int'(task_count_r) > MAX_TASKS) begin
      ring_n = CW'(MAX_TASKS);
    end else begin
      ring_n = CW'(task_count_r);
    end
  end

  assign ra_inc    = ra_r + CW'(1);
  assign ra_nxt    = (ra_inc == ring_n) ? '0 : ra_inc;
  assign cur_inc   = CW'(cur_r) + CW'(1);
  assign cur_nx    = (cur_inc == ring_n) ? '0 : cur_inc;
  assign cur_clamp = (CW'(cur_task_r) < ring_n) ? cur_task_r : '0;

  assign eff_st = st_qv_r ? st_q_r : TS_READY;
  assign eff_dl = dl_qv_r ? dl_q_r : '0;
  assign dl_dec = eff_dl - DELAY_BITS'(1);

  assign hit       = (ea_r == cur_r) || ((eff_st == TS_READY) && (ea_r != '0));
  assign srch_hit  = cmd.srch && rv_r && hit;
  assign srch_pick = (eff_st == TS_READY) ? ea_r : '0;

  assign idx_ext  = {{AW{1'b0}}, idx_r};
  assign idx_ok   = idx_ext < (AW + IDX_W)'(MAX_TASKS);
  assign widx_ext = idx_ext;
  assign sdel_ext = {{DELAY_BITS{1'b0}}, sdel_r};
  assign op_sched = (op_r == OP_DISPATCH) || (op_r == OP_YIELD);

  // read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ra_r[AW-1:0];
    if (cmd.cd && (ra_r != ring_n)) begin
      rd_en = 1'b1;
    end
    if (cmd.cur_rd) begin
      rd_en   = 1'b1;
      rd_addr = cur_r;
    end
    if (cmd.srch && !srch_hit) begin
      rd_en = 1'b1;
    end
  end

  // write port select
  always_comb begin
    st_we = 1'b0;
    st_wa = ea_r;
    st_wd = TS_READY;
    dl_we = 1'b0;
    dl_wa = ea_r;
    dl_wd = dl_dec;
    if (cmd.cd && rv_r && (eff_st == TS_BLOCKED) && (eff_dl != '0)) begin
      dl_we = 1'b1;
      if (dl_dec == '0) begin
        st_we = 1'b1;
      end
    end
    if (cmd.cur_wb) begin
      st_wa = cur_r;
      if (op_r == OP_YIELD) begin
        st_we = 1'b1;
        st_wd = TS_BLOCKED;
      end else if (eff_st == TS_RUNNING) begin
        st_we = 1'b1;
      end
    end
    if (cmd.pick) begin
      st_we = 1'b1;
      st_wa = pick_r;
      st_wd = TS_RUNNING;
    end
    if (cmd.wr_slot && (op_r == OP_WRITE) && idx_ok) begin
      st_we = 1'b1;
      st_wa = widx_ext[AW-1:0];
      st_wd = sst_r;
      dl_we = 1'b1;
      dl_wa = widx_ext[AW-1:0];
      dl_wd = sdel_ext[DELAY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      st_q_r <= st_mem[rd_addr];
      dl_q_r <= dl_mem[rd_addr];
    end
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    if (dl_we) begin
      dl_mem[dl_wa] <= dl_wd;
    end
  end

  // entries never written read as ready with zero delay
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
      dl_vld_r <= '0;
      st_qv_r  <= 1'b0;
      dl_qv_r  <= 1'b0;
    end else begin
      if (st_we) begin
        st_vld_r[st_wa] <= 1'b1;
      end
      if (dl_we) begin
        dl_vld_r[dl_wa] <= 1'b1;
      end
      if (rd_en) begin
        st_qv_r <= st_vld_r[rd_addr];
        dl_qv_r <= dl_vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= TC_W'(1);
      cur_task_r   <= '0;
      out_valid_r  <= 1'b0;
      rv_r         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        task_count_r <= cfg_data;
      end
      if (cmd.pick) begin
        cur_task_r <= pick_r;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.cap || cmd.cur_wb) begin
        rv_r <= 1'b0;
      end else if (cmd.cd || cmd.srch) begin
        rv_r <= rd_en;
      end
    end
  end

  assign cur_wide = {{TASK_W{1'b0}}, cur_task_r};

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_opcode;
      idx_r  <= in_slot_index;
      sst_r  <= in_slot_state;
      sdel_r <= in_slot_delay;
      cur_r  <= cur_clamp;
      ra_r   <= '0;
    end else if (cmd.cd && rd_en) begin
      ra_r <= ra_inc;
    end else if (cmd.cur_wb) begin
      ra_r <= cur_nx;
    end else if (cmd.srch && !srch_hit) begin
      ra_r <= ra_nxt;
    end
    if ((cmd.cd || cmd.srch) && rd_en) begin
      ea_r <= ra_r[AW-1:0];
    end
    if (srch_hit) begin
      pick_r <= srch_pick;
    end
    if (cmd.load) begin
      next_task_r <= cur_wide[TASK_W-1:0];
      went_idle_r <= op_sched && (cur_task_r == '0);
    end
  end

  assign sts.in_sched = (in_opcode == OP_DISPATCH) || (in_opcode == OP_YIELD);
  assign sts.cd_done  = (ra_r == ring_n) && !rv_r;
  assign sts.srch_hit = srch_hit;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_next_task = next_task_r;
  assign out_went_idle = went_idle_r;

endmodule

`default_nettype wire

// File: rtl/round_robin_task_scheduler_unit.sv
// top level of the round robin task scheduler
// dispatch or yield: a delay countdown over the ring of slots, the current slot update, then a
// search from the slot after the current one, then the pick and the result; a slot write or
// unused opcode goes through the slot write step and then the result
// a stalled result holds the next request at its last step; one request in work at a time
// reset is synchronous active low: all slots ready with zero delay, current slot idle
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_scheduler_unit #(
  parameter int MAX_TASKS  = 16,
  parameter int DELAY_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  rrts_in_if.sink     in_if,
  rrts_out_if.source  out_if,
  rrts_cfg_if.sink    cfg_if
);
  import rrts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrts_datapath #(
    .MAX_TASKS  (MAX_TASKS),
    .DELAY_BITS (DELAY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (in_if.opcode),
    .in_slot_index (in_if.slot_index),
    .in_slot_state (in_if.slot_state),
    .in_slot_delay (in_if.slot_delay),
    .cfg_valid     (cfg_if.valid),
    .cfg_data      (cfg_if.data),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_next_task (out_if.next_task),
    .out_went_idle (out_if.went_idle)
  );

  assign in_if.ready  = cmd.in_ready;
  assign cfg_if.ready = 1'b1;

endmodule

`default_nettype wire

// File: rtl/rrts_checker.sv
// port level checker for the round robin task scheduler and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_task_scheduler_unit_defines.svh"

module rrts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] next_task,
  input logic       went_idle
);

  `RRTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_task) && $stable(went_idle), "stalled result changed")

  `RRTS_ASSERT_IMP(a_idle_slot, out_valid && went_idle, next_task == 4'd0, "idle result names a nonzero slot")

  `RRTS_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while one is in work")

  `RRTS_ASSERT_NXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after request")

endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .next_task (out_if.next_task),
  .went_idle (out_if.went_idle)
);

`default_nettype wire
